/* rtl/core/argbtb_pkg.sv */
// Package for the ARGB tint and alpha blend unit.
// Holds register indexes, channel constants and the divide-by-255 helper.
// No dependencies.
`default_nettype none

package argbtb_pkg;

	localparam int unsigned CH_W      = 8;
	localparam int unsigned PIX_W     = 32;
	localparam int unsigned CFG_W     = 24;
	localparam int unsigned NUM_CH    = 3;

	// Register indexes of the configuration port
	typedef enum logic [0:0] {
		CFG_TINT_ENABLE = 1'b0,
		CFG_TINT_COLOR  = 1'b1
	} cfg_idx_t;

	localparam logic [CFG_W-1:0] TINT_COLOR_RESET = 24'hFFFFFF;

	// Reciprocal of 3 in Q11: floor(x * 683 / 2048) == floor(x / 3) for x <= 765
	localparam logic [9:0] RECIP3_Q11 = 10'd683;

	typedef logic [CH_W-1:0] chan_t;

	// floor(x / 255), exact for x below 65280
	function automatic chan_t div255(input logic [15:0] x);
		logic [16:0] t;
		t = {1'b0, x} + 17'(x[15:8]) + 17'd1;
		return t[15:8];
	endfunction

endpackage

`default_nettype wire

/* rtl/core/argb_tint_alpha_blend_unit.sv */
// Top level of the ARGB8888 tint and alpha blend unit.
// Depends on argbtb_pkg for register indexes, constants and div255.
// Six-stage pipeline, one pixel per clock unless the output stream stalls it.
`default_nettype none

// Usage:
//   Slave stream s_axis_*: one beat carries a destination and a source pixel,
//   both 0xAARRGGBB. Master stream m_axis_*: one blended pixel per input beat,
//   in order, alpha copied from the destination.
//   Configuration port: cfg_wen with cfg_index 0 writes tint_enable (bit 0),
//   index 1 writes tint_color (0xRRGGBB). Write only while the pipe is empty.
//   Throughput: one beat per clock unless m_axis_tready holds the output;
//   every stage holds its own valid bit and loads whenever it is empty or
//   the stage after it moves on, so bubbles collapse and the input side
//   keeps taking beats while a result waits.
//   Stages: s1 input register and grey sum, s2 grey by reciprocal multiply,
//   s3 tint multiplies, s4 tint scaling and signed channel difference,
//   s5 difference times alpha, s6 signed divide by 255 and final add.
//   Reset: arst_n clears all valid bits, tint_enable to 0 and tint_color
//   to 0xFFFFFF. When m_axis_tready is low the output beat holds, the stages
//   behind it fill up, and then s_axis_tready drops; nothing is lost or
//   repeated.

module argb_tint_alpha_blend_unit
	import argbtb_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration write port
	input  wire logic              cfg_wen,
	input  wire logic [0:0]        cfg_index,
	input  wire logic [CFG_W-1:0]  cfg_wdata,
	// input stream
	input  wire logic              s_axis_tvalid,
	output logic                   s_axis_tready,
	input  wire logic [63:0]       s_axis_tdata,  // [31:0] dest_pixel, [63:32] source_pixel
	// output stream
	output logic                   m_axis_tvalid,
	input  wire logic              m_axis_tready,
	output logic [PIX_W-1:0]       m_axis_tdata   // [31:0] blended_pixel
);

	// Configuration registers
	logic              tint_enable_q;
	logic [CFG_W-1:0]  tint_color_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tint_enable_q <= 1'b0;
			tint_color_q  <= TINT_COLOR_RESET;
		end else if (cfg_wen) begin
			case (cfg_idx_t'(cfg_index))
				CFG_TINT_ENABLE: tint_enable_q <= cfg_wdata[0];
				CFG_TINT_COLOR:  tint_color_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Per-stage valid and load enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic ld1, ld2, ld3, ld4, ld5, ld6;

	assign ld6 = !v_s6 || m_axis_tready;
	assign ld5 = !v_s5 || ld6;
	assign ld4 = !v_s4 || ld5;
	assign ld3 = !v_s3 || ld4;
	assign ld2 = !v_s2 || ld3;
	assign ld1 = !v_s1 || ld2;

	assign s_axis_tready = ld1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= s_axis_tvalid;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
			if (ld6) v_s6 <= v_s5;
		end
	end

	// Stage 1: capture pixels, sum source colour channels
	logic [PIX_W-1:0] dst_s1, src_s1;
	logic [9:0]       sum_s1;
	logic             en_s1;

	always_ff @(posedge clk) begin
		if (ld1) begin
			dst_s1 <= s_axis_tdata[31:0];
			src_s1 <= s_axis_tdata[63:32];
			en_s1  <= tint_enable_q;
			sum_s1 <= 10'(s_axis_tdata[39:32]) + 10'(s_axis_tdata[47:40])
			        + 10'(s_axis_tdata[55:48]);
		end
	end

	// Stage 2: grey = sum / 3 through the Q11 reciprocal
	logic [PIX_W-1:0] dst_s2, src_s2;
	chan_t            grey_s2;
	logic             en_s2;
	logic [19:0]      grey_prod;

	assign grey_prod = 20'(sum_s1) * 20'(RECIP3_Q11);

	always_ff @(posedge clk) begin
		if (ld2) begin
			dst_s2  <= dst_s1;
			src_s2  <= src_s1;
			en_s2   <= en_s1;
			grey_s2 <= grey_prod[18:11];
		end
	end

	// Stage 3: tint channel times grey
	logic [PIX_W-1:0] dst_s3, src_s3;
	logic [15:0]      tprod_s3 [NUM_CH];
	logic             en_s3;

	always_ff @(posedge clk) begin
		if (ld3) begin
			dst_s3 <= dst_s2;
			src_s3 <= src_s2;
			en_s3  <= en_s2;
			for (int i = 0; i < NUM_CH; i++) begin
				tprod_s3[i] <= 16'(tint_color_q[i*CH_W +: CH_W]) * 16'(grey_s2);
			end
		end
	end

	// Stage 4: pick plain or tinted source colour, take signed difference
	logic [PIX_W-1:0]  dst_s4;
	chan_t             alpha_s4;
	logic signed [8:0] diff_s4 [NUM_CH];
	chan_t             sc [NUM_CH];

	always_comb begin
		for (int i = 0; i < NUM_CH; i++) begin
			sc[i] = en_s3 ? div255(tprod_s3[i]) : src_s3[i*CH_W +: CH_W];
		end
	end

	always_ff @(posedge clk) begin
		if (ld4) begin
			dst_s4   <= dst_s3;
			alpha_s4 <= src_s3[31:24];
			for (int i = 0; i < NUM_CH; i++) begin
				diff_s4[i] <= $signed({1'b0, sc[i]}) - $signed({1'b0, dst_s3[i*CH_W +: CH_W]});
			end
		end
	end

	// Stage 5: difference times source alpha
	logic [PIX_W-1:0]   dst_s5;
	logic signed [17:0] bprod_s5 [NUM_CH];

	always_ff @(posedge clk) begin
		if (ld5) begin
			dst_s5 <= dst_s4;
			for (int i = 0; i < NUM_CH; i++) begin
				bprod_s5[i] <= 18'(diff_s4[i]) * 18'($signed({1'b0, alpha_s4}));
			end
		end
	end

	// Stage 6: divide by 255 toward zero, add back to destination
	logic [PIX_W-1:0]   out_s6;
	logic [PIX_W-1:0]   res;
	logic signed [17:0] mag [NUM_CH];
	chan_t              q [NUM_CH];

	always_comb begin
		res = {dst_s5[31:24], 24'd0};
		for (int i = 0; i < NUM_CH; i++) begin
			mag[i] = bprod_s5[i][17] ? -bprod_s5[i] : bprod_s5[i];
			q[i]   = div255(mag[i][15:0]);
			res[i*CH_W +: CH_W] = bprod_s5[i][17] ? dst_s5[i*CH_W +: CH_W] - q[i]
			                                      : dst_s5[i*CH_W +: CH_W] + q[i];
		end
	end

	always_ff @(posedge clk) begin
		if (ld6) begin
			out_s6 <= res;
		end
	end

	assign m_axis_tvalid = v_s6;
	assign m_axis_tdata  = out_s6;

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench for argb_tint_alpha_blend_unit: random and directed pixel pairs
// with tint settings, checked beat by beat against an in-bench blend predictor.
// Depends on argbtb_pkg for the register indexes and port widths.
`timescale 1ns / 1ps

module tb;
	import argbtb_pkg::*;

	localparam int IDLE_LIMIT = 5000;  // cycles with no beat on either side
	localparam int PIPE_DEPTH = 6;     // pipeline stages
	localparam int PHASES     = 12;
	localparam int PHASE_ITEMS = 111;
	localparam int HOLD_LEN   = 300;   // long receiver hold-off in cycles

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_wen;
	logic [0:0]        cfg_index;
	logic [CFG_W-1:0]  cfg_wdata;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [63:0]       s_axis_tdata;   // [31:0] dest_pixel, [63:32] source_pixel
	logic              m_axis_tvalid;
	logic              m_axis_tready = 1'b0;
	logic [PIX_W-1:0]  m_axis_tdata;   // [31:0] blended_pixel

	int src_idle_pct;
	int sink_stall_pct;
	int hold_req = 0;      // bumped by the main sequence to ask for a hold-off
	int hold_seen = 0;
	int hold_cycles = 0;
	int idle_cycles = 0;

	// Blend predictor plus the queue of pixels still owed by the pipe.
	class blend_scoreboard;
		logic [31:0]      owed_pixels[$];
		logic             tint_en;
		logic [CFG_W-1:0] tint_col;
		int               mismatches;

		function new();
			tint_en    = 1'b0;
			tint_col   = TINT_COLOR_RESET;
			mismatches = 0;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $realtime, msg);
			mismatches++;
		endtask

		function void write_reg(logic [0:0] idx, logic [CFG_W-1:0] val);
			case (cfg_idx_t'(idx))
				CFG_TINT_ENABLE: tint_en = val[0];
				CFG_TINT_COLOR:  tint_col = val;
				default: ;
			endcase
		endfunction

		function logic [31:0] blend(logic [31:0] dst, logic [31:0] src);
			int grey;
			int alpha;
			int diff;
			logic [31:0] colour;
			logic [31:0] res;
			colour = src;
			// swap the source colour for the grey-scaled tint, keep its alpha
			if (tint_en) begin
				grey = (int'(src[7:0]) + int'(src[15:8]) + int'(src[23:16])) / 3;
				for (int c = 0; c < 3; c++)
					colour[8*c +: 8] = 8'((int'(tint_col[8*c +: 8]) * grey) / 255);
			end
			alpha = int'(colour[31:24]);
			res = {dst[31:24], 24'h0};
			// signed difference, division truncates toward zero
			for (int c = 0; c < 3; c++) begin
				diff = int'(colour[8*c +: 8]) - int'(dst[8*c +: 8]);
				res[8*c +: 8] = 8'(int'(dst[8*c +: 8]) + (diff * alpha) / 255);
			end
			return res;
		endfunction

		function void note_input(logic [31:0] dst, logic [31:0] src);
			owed_pixels.insert(owed_pixels.size(), blend(dst, src));
		endfunction

		task check_result(logic [31:0] got);
			logic [31:0] want;
			if (owed_pixels.size() == 0) begin
				report($sformatf("unexpected output beat %08h", got));
			end else begin
				want = owed_pixels.pop_front();
				if (got !== want)
					report($sformatf("blended_pixel got %08h want %08h", got, want));
			end
		endtask
	endclass

	blend_scoreboard sb = new();

	argb_tint_alpha_blend_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wen       (cfg_wen),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// Monitor: sample both streams and the config port at the rising edge.
	// Check the output before noting the input so a fresh beat never pairs
	// with a result that was already owed.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wen)
				sb.write_reg(cfg_index, cfg_wdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready)
				sb.note_input(s_axis_tdata[31:0], s_axis_tdata[63:32]);
		end
	end

	// Watchdog: count cycles with no beat on either stream.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Receiver: a long hold-off counts down here on its own; otherwise stall
	// at the current rate. Drive on the falling edge, away from sampling.
	always @(negedge clk) begin
		if (hold_req != hold_seen) begin
			hold_seen   = hold_req;
			hold_cycles = HOLD_LEN;
		end
		if (hold_cycles > 0) begin
			m_axis_tready = 1'b0;
			hold_cycles--;
		end else begin
			m_axis_tready = ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// Offer one beat, idling first at the sender rate; hold until accepted.
	task send_pixels(logic [31:0] dst, logic [31:0] src);
		@(negedge clk);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid = 1'b0;
			s_axis_tdata  = {$urandom, $urandom};
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata  = {src, dst};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	// Drop valid and wait out every owed pixel before going on.
	task drain_pipe();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.owed_pixels.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 2) @(posedge clk);
	endtask

	task write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
		@(negedge clk);
		cfg_wen   = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(negedge clk);
		cfg_wen   = 1'b0;
		cfg_wdata = '0;
	endtask

	// Random pixel; lean on the alpha extremes and flat channels now and then.
	function automatic logic [31:0] rand_pixel();
		logic [31:0] px;
		px = $urandom;
		case ($urandom_range(9))
			0: px[31:24] = 8'h00;
			1: px[31:24] = 8'hFF;
			2: px[23:0]  = 24'h000000;
			3: px[23:0]  = 24'hFFFFFF;
			default: ;
		endcase
		return px;
	endfunction

	// Directed pairs: extremes, source above and below destination, both alphas.
	task run_directed();
		send_pixels(32'h0000_0000, 32'h0000_0000);
		send_pixels(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_pixels(32'hFFFF_FFFF, 32'h00FF_FFFF);  // source alpha zero
		send_pixels(32'h12FF_FFFF, 32'hFF00_0000);  // source alpha full, below dest
		send_pixels(32'h0000_0000, 32'hFFFF_FFFF);  // full alpha, above dest
		send_pixels(32'hA0C0_8040, 32'h8020_F010);  // mixed signs per channel
		send_pixels(32'h00FF_00FF, 32'h7F00_FF00);
		send_pixels(32'hFF01_0203, 32'h01FE_FDFC);  // alpha one
		send_pixels(32'h5555_5555, 32'hFEAA_AAAA);
		send_pixels(32'hFFFF_FFFF, 32'h8000_0000);
	endtask

	initial begin
		logic [CFG_W-1:0] colour;
		arst_n         = 1'b0;
		cfg_wen        = 1'b0;
		cfg_index      = '0;
		cfg_wdata      = '0;
		s_axis_tvalid  = 1'b0;
		s_axis_tdata   = '0;
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		// reset settings first: tint off, white tint colour
		run_directed();
		drain_pipe();
		write_reg(CFG_TINT_ENABLE, 24'h000001);
		run_directed();
		drain_pipe();
		write_reg(CFG_TINT_COLOR, 24'h000000);
		send_pixels(32'h8040_2010, 32'hFFFF_FFFF);  // black tint, full alpha
		send_pixels(32'h8040_2010, 32'h80FF_8000);

		for (int p = 0; p < PHASES; p++) begin
			drain_pipe();
			// rotate through tint off/on and colour extremes; noise in upper bits
			case (p % 4)
				0: colour = 24'hFFFFFF;
				1: colour = 24'h000000;
				2: colour = 24'($urandom);
				default: colour = {8'($urandom_range(255)), 8'h00,
				                   8'($urandom_range(255))};
			endcase
			write_reg(CFG_TINT_COLOR, colour);
			write_reg(CFG_TINT_ENABLE, {23'($urandom), p[1] ^ p[0]});

			case (p % 4)
				0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
				1: begin src_idle_pct = 64; sink_stall_pct = 0;  end
				2: begin src_idle_pct = 0;  sink_stall_pct = 64; end
				default: begin src_idle_pct = 14; sink_stall_pct = 14; end
			endcase
			// long receiver hold-off while the sender keeps offering beats
			if (p == 4 || p == 9)
				hold_req++;

			for (int i = 0; i < PHASE_ITEMS; i++)
				send_pixels(rand_pixel(), rand_pixel());
		end

		drain_pipe();
		repeat (20) @(posedge clk);
		if (sb.owed_pixels.size() != 0)
			sb.report($sformatf("%0d pixels never came out", sb.owed_pixels.size()));
		if (sb.mismatches == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
